// ----- rtl/fan_curve_pwm_with_hysteresis_assert.svh -----
// assertion helpers shared by the fan curve rtl
// every user module has clock and reset (synchronous, active high) in scope
`ifndef FAN_CURVE_PWM_WITH_HYSTERESIS_ASSERT_SVH
`define FAN_CURVE_PWM_WITH_HYSTERESIS_ASSERT_SVH

// condition holds at every edge out of reset
`define FCP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FCP_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define FCP_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/fcp_pkg.sv -----
`default_nettype none

package fcp_pkg;

   // field widths
   localparam int TEMP_W     = 8;
   localparam int HYST_W     = 7;
   localparam int DUTY_W     = 9;
   localparam int PCT_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   // pwm resolution and saturation limit
   localparam int PWM_BITS = 8;
   localparam logic [16:0] DUTY_LIMIT = 17'(1) << PWM_BITS;

   // divider sizing
   localparam int DIV_NUM_W = 16;
   localparam int DIV_DEN_W = 9;
   localparam int DIV_CNT_W = 4;

   // percent scale
   localparam logic [DIV_DEN_W-1:0] PCT_SCALE = DIV_DEN_W'(100);

   // reciprocal of one hundred, exact floor for products below 91180
   localparam int RECIP_SHIFT  = 23;
   localparam int RECIP_W      = 17;
   localparam int SCALE_PROD_W = DIV_NUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(83887);

   // register reset values
   localparam logic signed [TEMP_W-1:0] LOW_TEMP_RST  = TEMP_W'(30);
   localparam logic signed [TEMP_W-1:0] HIGH_TEMP_RST = TEMP_W'(50);
   localparam logic [HYST_W-1:0]        HYST_RST      = HYST_W'(3);
   localparam logic [DUTY_W-1:0]        FLOOR_RST     = DUTY_W'(0);
   localparam logic [DUTY_W-1:0]        CEIL_RST      = DUTY_W'(DUTY_LIMIT);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_TEMP     = 3'd0,
      CSR_HIGH_TEMP    = 3'd1,
      CSR_HYSTERESIS   = 3'd2,
      CSR_DUTY_FLOOR   = 3'd3,
      CSR_DUTY_CEILING = 3'd4
   } csr_index_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV_PCT,
      ST_MUL,
      ST_SCALE,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_sample;
      logic pick_edge;
      logic start_div_pct;
      logic take_pct;
      logic do_mul;
      logic take_scale;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_high;
      logic at_low;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/fcp_req_if.sv -----
`default_nettype none

interface fcp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fcp_pkg::TEMP_W-1:0]    temperature;

   modport source (output valid, output temperature, input ready);
   modport sink   (input valid, input temperature, output ready);
endinterface

`default_nettype wire

// ----- rtl/fcp_rsp_if.sv -----
`default_nettype none

interface fcp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fcp_pkg::DUTY_W-1:0]    duty;
   logic                          duty_changed;

   modport source (output valid, output duty, output duty_changed, input ready);
   modport sink   (input valid, input duty, input duty_changed, output ready);
endinterface

`default_nettype wire

// ----- rtl/fan_curve_pwm_with_hysteresis.sv -----
`default_nettype none

// channel   dir  handshake               payload
// req_chan  in   valid / ready           temperature[7:0] signed
// rsp_chan  out  valid / ready           duty[8:0], duty_changed
// csr_*     in   csr_we (no back-pressure) csr_index[2:0], csr_wdata[8:0]
//
// a sample in the linear region passes evaluate, the 16-step restoring divider
// for the percent, multiply, reciprocal scale and commit
// a sample at or beyond either threshold goes from evaluate straight to commit
// a new sample is taken only after the previous one has committed
// reset is synchronous and loads the register defaults; no clearing pass
// the result waits in an output register; the next sample is taken meanwhile,
// and its commit waits only if the earlier result is still not taken
module fan_curve_pwm_with_hysteresis (
   input  wire logic                                clock,
   input  wire logic                                reset,
   fcp_req_if.sink                                  req_chan,
   fcp_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_we,
   input  wire logic [fcp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fcp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   fcp_pkg::ctrl_cmd_type  cmd;
   fcp_pkg::dp_status_type status;
   logic                   req_ready;
   logic                   rsp_valid;
   logic [fcp_pkg::DUTY_W-1:0] rsp_duty;
   logic                   rsp_duty_changed;

   // sequencing
   fcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, state and result register
   fcp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .temperature      (req_chan.temperature),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_duty         (rsp_duty),
      .rsp_duty_changed (rsp_duty_changed)
   );

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.duty         = rsp_duty;
   assign rsp_chan.duty_changed = rsp_duty_changed;

endmodule

`default_nettype wire

// ----- rtl/fcp_div.sv -----
`default_nettype none
`include "fan_curve_pwm_with_hysteresis_assert.svh"

// restoring divider, one quotient bit per cycle
module fcp_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [fcp_pkg::DIV_NUM_W-1:0]     dividend,
   input  wire logic [fcp_pkg::DIV_DEN_W-1:0]     divisor,
   output      logic                              done,
   output      logic [fcp_pkg::DIV_NUM_W-1:0]     quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [fcp_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [fcp_pkg::DIV_DEN_W-1:0]      rem_ff, rem_in;
   logic [fcp_pkg::DIV_DEN_W-1:0]      dvsr_ff, dvsr_in;
   logic [fcp_pkg::DIV_NUM_W-1:0]      quo_ff, quo_in;
   logic [fcp_pkg::DIV_DEN_W:0]        trial;
   logic [fcp_pkg::DIV_DEN_W:0]        diff;
   logic                               fits;

   // one restoring step
   assign trial = {rem_ff, quo_ff[fcp_pkg::DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, dvsr_ff};
   assign fits  = (trial >= {1'b0, dvsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '1;
         rem_in  = '0;
         dvsr_in = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[fcp_pkg::DIV_DEN_W-1:0] : trial[fcp_pkg::DIV_DEN_W-1:0];
         quo_in = {quo_ff[fcp_pkg::DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `FCP_ASSERT_NEXT(a_div_start_busy, start, busy_ff && !done_ff, "divider did not start")
   `FCP_ASSERT_ALWAYS(a_div_busy_done_excl, !(busy_ff && done_ff), "divider busy and done")

endmodule

`default_nettype wire

// ----- rtl/fcp_dp.sv -----
`default_nettype none
`include "fan_curve_pwm_with_hysteresis_assert.svh"

module fcp_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [fcp_pkg::TEMP_W-1:0]   temperature,
   input  wire logic                                csr_we,
   input  wire logic [fcp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fcp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire fcp_pkg::ctrl_cmd_type               cmd,
   output      fcp_pkg::dp_status_type              status,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [fcp_pkg::DUTY_W-1:0]          rsp_duty,
   output      logic                                rsp_duty_changed
);

   // configuration registers
   logic signed [fcp_pkg::TEMP_W-1:0]  low_ff, high_ff;
   logic [fcp_pkg::HYST_W-1:0]         hyst_ff;
   logic [fcp_pkg::DUTY_W-1:0]         floor_ff, ceil_ff;

   // block state
   logic signed [fcp_pkg::TEMP_W-1:0]  prev_ff;
   logic [fcp_pkg::DUTY_W-1:0]         cur_ff;

   // per-sample working registers
   logic signed [fcp_pkg::TEMP_W-1:0]  t_ff;
   logic [fcp_pkg::PCT_W-1:0]          pct_ff;
   logic [fcp_pkg::DIV_NUM_W-1:0]      prod_ff;
   logic [fcp_pkg::DUTY_W-1:0]         d_ff, d_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [fcp_pkg::DUTY_W-1:0]         rsp_duty_ff;
   logic                               rsp_changed_ff;

   logic                               fall_off;
   logic signed [fcp_pkg::DUTY_W-1:0]  lo_w;
   logic signed [fcp_pkg::DUTY_W:0]    lo_x, t_x, high_x;
   logic [fcp_pkg::DUTY_W:0]           rise_x, span_x;
   logic [fcp_pkg::DIV_NUM_W-1:0]      num_w;
   logic signed [fcp_pkg::DUTY_W:0]    gap;
   logic [fcp_pkg::DUTY_W-1:0]         gap_mag;
   logic                               gap_neg_ff;
   logic                               div_start, div_done;
   logic [fcp_pkg::DIV_NUM_W-1:0]      div_num, div_quo;
   logic [fcp_pkg::DIV_DEN_W-1:0]      div_den;
   logic [fcp_pkg::SCALE_PROD_W-1:0]   scale_prod;
   logic [fcp_pkg::DUTY_W-1:0]         scale_quo;
   logic signed [fcp_pkg::DUTY_W+1:0]  d_scaled;
   logic                               dirty;
   logic [fcp_pkg::DUTY_W-1:0]         d_sat;

   // effective low threshold, lowered while falling with the fan off
   assign fall_off = (t_ff < prev_ff) && (cur_ff == '0);
   assign lo_w     = {low_ff[fcp_pkg::TEMP_W-1], low_ff}
                   - {2'b00, (fall_off ? hyst_ff : '0)};

   // threshold compares, sign extended to a common width
   assign lo_x   = {lo_w[fcp_pkg::DUTY_W-1], lo_w};
   assign t_x    = {{2{t_ff[fcp_pkg::TEMP_W-1]}}, t_ff};
   assign high_x = {{2{high_ff[fcp_pkg::TEMP_W-1]}}, high_ff};

   assign status.at_high = (t_ff >= high_ff);
   assign status.at_low  = (t_x <= lo_x);

   // percent numerator and span, both positive when interpolating
   assign rise_x = t_x - lo_x;
   assign span_x = high_x - lo_x;
   assign num_w  = fcp_pkg::DIV_NUM_W'(rise_x[fcp_pkg::DUTY_W-1:0])
                 * fcp_pkg::DIV_NUM_W'(fcp_pkg::PCT_SCALE);

   // divider for the percent step
   assign div_start = cmd.start_div_pct;
   assign div_num   = num_w;
   assign div_den   = span_x[fcp_pkg::DUTY_W-1:0];

   fcp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign status.div_done = div_done;

   // signed duty span, handled as magnitude and sign
   assign gap     = {1'b0, ceil_ff} - {1'b0, floor_ff};
   assign gap_mag = gap[fcp_pkg::DUTY_W] ? fcp_pkg::DUTY_W'(-gap) : gap[fcp_pkg::DUTY_W-1:0];

   // scale back by one hundred through the reciprocal
   assign scale_prod = fcp_pkg::SCALE_PROD_W'(prod_ff)
                     * fcp_pkg::SCALE_PROD_W'(fcp_pkg::RECIP_100);
   assign scale_quo  = scale_prod[fcp_pkg::RECIP_SHIFT +: fcp_pkg::DUTY_W];

   // interpolated duty, quotient applied toward zero
   assign d_scaled = gap_neg_ff
                   ? {2'b00, floor_ff} - {2'b00, scale_quo}
                   : {2'b00, floor_ff} + {2'b00, scale_quo};

   always_comb begin
      d_in = d_ff;
      if (cmd.pick_edge) begin
         d_in = status.at_high ? ceil_ff : floor_ff;
      end else if (cmd.take_scale) begin
         d_in = d_scaled[fcp_pkg::DUTY_W-1:0];
      end
   end

   // commit values
   assign dirty = (d_ff != cur_ff);
   assign d_sat = ({8'd0, d_ff} > fcp_pkg::DUTY_LIMIT)
                ? fcp_pkg::DUTY_W'(fcp_pkg::DUTY_LIMIT) : d_ff;

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= fcp_pkg::LOW_TEMP_RST;
         high_ff  <= fcp_pkg::HIGH_TEMP_RST;
         hyst_ff  <= fcp_pkg::HYST_RST;
         floor_ff <= fcp_pkg::FLOOR_RST;
         ceil_ff  <= fcp_pkg::CEIL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            fcp_pkg::CSR_LOW_TEMP:     low_ff   <= csr_wdata[fcp_pkg::TEMP_W-1:0];
            fcp_pkg::CSR_HIGH_TEMP:    high_ff  <= csr_wdata[fcp_pkg::TEMP_W-1:0];
            fcp_pkg::CSR_HYSTERESIS:   hyst_ff  <= csr_wdata[fcp_pkg::HYST_W-1:0];
            fcp_pkg::CSR_DUTY_FLOOR:   floor_ff <= csr_wdata[fcp_pkg::DUTY_W-1:0];
            fcp_pkg::CSR_DUTY_CEILING: ceil_ff  <= csr_wdata[fcp_pkg::DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // block state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            prev_ff <= t_ff;
            if (dirty) begin
               cur_ff <= d_sat;
            end
         end
      end
   end

   // working registers and result payload
   always_ff @(posedge clock) begin
      d_ff <= d_in;
      if (cmd.load_sample) begin
         t_ff <= temperature;
      end
      if (cmd.take_pct) begin
         pct_ff <= div_quo[fcp_pkg::PCT_W-1:0];
      end
      if (cmd.do_mul) begin
         prod_ff    <= fcp_pkg::DIV_NUM_W'(gap_mag) * fcp_pkg::DIV_NUM_W'(pct_ff);
         gap_neg_ff <= gap[fcp_pkg::DUTY_W];
      end
      if (cmd.commit) begin
         rsp_duty_ff    <= dirty ? d_sat : cur_ff;
         rsp_changed_ff <= dirty;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty         = rsp_duty_ff;
   assign rsp_duty_changed = rsp_changed_ff;

   `FCP_ASSERT_ALWAYS(a_dp_duty_saturated, ({8'd0, cur_ff} <= fcp_pkg::DUTY_LIMIT),
                      "stored duty above limit")
   `FCP_ASSERT_NEXT(a_dp_commit_result, cmd.commit,
                    rsp_valid_ff && (rsp_duty_ff == cur_ff), "result does not match duty")

endmodule

`default_nettype wire

// ----- rtl/fcp_ctrl.sv -----
`default_nettype none
`include "fan_curve_pwm_with_hysteresis_assert.svh"

module fcp_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire fcp_pkg::dp_status_type   status,
   output      fcp_pkg::ctrl_cmd_type    cmd
);

   fcp_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fcp_pkg::ST_IDLE: begin
            if (req_valid) state_in = fcp_pkg::ST_EVAL;
         end
         fcp_pkg::ST_EVAL: begin
            if (status.at_high || status.at_low) state_in = fcp_pkg::ST_FINISH;
            else state_in = fcp_pkg::ST_DIV_PCT;
         end
         fcp_pkg::ST_DIV_PCT: begin
            if (status.div_done) state_in = fcp_pkg::ST_MUL;
         end
         fcp_pkg::ST_MUL: begin
            state_in = fcp_pkg::ST_SCALE;
         end
         fcp_pkg::ST_SCALE: begin
            state_in = fcp_pkg::ST_FINISH;
         end
         fcp_pkg::ST_FINISH: begin
            if (status.out_free) state_in = fcp_pkg::ST_IDLE;
         end
         default: state_in = fcp_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         fcp_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.load_sample = req_valid;
         end
         fcp_pkg::ST_EVAL: begin
            if (status.at_high || status.at_low) cmd.pick_edge = 1'b1;
            else cmd.start_div_pct = 1'b1;
         end
         fcp_pkg::ST_DIV_PCT: begin
            cmd.take_pct = status.div_done;
         end
         fcp_pkg::ST_MUL: begin
            cmd.do_mul = 1'b1;
         end
         fcp_pkg::ST_SCALE: begin
            cmd.take_scale = 1'b1;
         end
         fcp_pkg::ST_FINISH: begin
            cmd.commit = status.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `FCP_ASSERT_SAME(a_ctrl_commit_room, cmd.commit, status.out_free,
                    "commit with result register full")
   `FCP_ASSERT_NEXT(a_ctrl_accept_eval, (state_ff == fcp_pkg::ST_IDLE) && req_valid,
                    state_ff == fcp_pkg::ST_EVAL, "transfer not followed by evaluation")

endmodule

`default_nettype wire
